/* rtl/core/mlfr_pkg.sv */
// Shared constants, codes and control types for the minmod face reconstruction block.
`default_nettype none
package mlfr_pkg;

    localparam int DW       = 32;            // data word width
    localparam int FB       = 16;            // fraction bits
    localparam int DIFF_W   = DW + 1;        // value difference
    localparam int DEN_W    = DW + 2;        // slope denominator width (central one grows most)
    localparam int UN_W     = DIFF_W + 1;    // 2 * |difference|
    localparam int DVD_W    = UN_W + FB;     // divider dividend
    localparam int CNT_W    = 6;             // divider step counter
    localparam int PROD_W   = DW + DIFF_W;   // slope magnitude * |cell width|
    localparam int OFF_W    = PROD_W - FB - 1;
    localparam int SUM_W    = OFF_W + 2;

    localparam logic signed [DW-1:0] DW_MAX = {1'b0, {(DW-1){1'b1}}};
    localparam logic signed [DW-1:0] DW_MIN = {1'b1, {(DW-1){1'b0}}};

    // quantity codes
    localparam logic [1:0] QTY_DENS = 2'd0;
    localparam logic [1:0] QTY_PRES = 2'd1;
    localparam logic [1:0] QTY_VELO = 2'd2;

    // slope codes
    localparam logic [1:0] SLP_LEFT  = 2'd0;
    localparam logic [1:0] SLP_RIGHT = 2'd1;
    localparam logic [1:0] SLP_CENT  = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PREP,
        ST_DSTART,
        ST_DWAIT,
        ST_MINMOD,
        ST_MUL,
        ST_FACE,
        ST_OUT,
        ST_SHIFT
    } t_state;

    typedef struct packed {
        logic       load;
        logic       prep;
        logic       div_start;
        logic       save;
        logic       minmod;
        logic       mul;
        logic       face;
        logic       out_load;
        logic       shift;
        logic [1:0] qty;
        logic [1:0] slp;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic div_busy;
        logic out_free;
    } t_sts;

endpackage
`default_nettype wire

/* rtl/core/mlfr_div.sv */
// Restoring radix-2 divider, one quotient bit per cycle.
`default_nettype none
module mlfr_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [mlfr_pkg::DVD_W-1:0]    i_dividend,
    input  wire logic [mlfr_pkg::DEN_W-1:0]    i_divisor,
    output logic                               o_busy,
    output logic [mlfr_pkg::DVD_W-1:0]         o_quotient
);

    logic [mlfr_pkg::CNT_W-1:0] r_cnt;
    logic                       r_busy;
    logic [mlfr_pkg::DEN_W-1:0] r_rem;
    logic [mlfr_pkg::DVD_W-1:0] r_quo;
    logic [mlfr_pkg::DEN_W-1:0] r_dsr;
    logic [mlfr_pkg::DEN_W:0]   w_rem_sh;
    logic [mlfr_pkg::DEN_W:0]   w_diff;
    logic                       w_ge;

    assign w_rem_sh = {r_rem, r_quo[mlfr_pkg::DVD_W-1]};
    assign w_diff   = w_rem_sh - {1'b0, r_dsr};
    assign w_ge     = w_rem_sh >= {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= mlfr_pkg::CNT_W'(mlfr_pkg::DVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == mlfr_pkg::CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[mlfr_pkg::DEN_W-1:0] : w_rem_sh[mlfr_pkg::DEN_W-1:0];
            r_quo <= {r_quo[mlfr_pkg::DVD_W-2:0], w_ge};
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_quo;

endmodule
`default_nettype wire

/* rtl/core/mlfr_ctrl.sv */
// Sequencer: with a full window, walks three quantities by three slopes, then hands the word out; else only shifts.
`default_nettype none
module mlfr_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_s_tvalid,
    output logic                  o_s_tready,
    input  wire mlfr_pkg::t_sts   i_sts,
    output mlfr_pkg::t_cmd        o_cmd
);

    mlfr_pkg::t_state r_state, n_state;
    logic [1:0]       r_qty, n_qty;
    logic [1:0]       r_slp, n_slp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mlfr_pkg::ST_IDLE;
            r_qty   <= mlfr_pkg::QTY_DENS;
            r_slp   <= mlfr_pkg::SLP_LEFT;
        end else begin
            r_state <= n_state;
            r_qty   <= n_qty;
            r_slp   <= n_slp;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_qty      = r_qty;
        n_slp      = r_slp;
        o_cmd      = '0;
        o_cmd.qty  = r_qty;
        o_cmd.slp  = r_slp;
        o_s_tready = 1'b0;
        case (r_state)
            mlfr_pkg::ST_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = mlfr_pkg::ST_CHECK;
                end
            end
            mlfr_pkg::ST_CHECK: begin
                n_qty = mlfr_pkg::QTY_DENS;
                n_slp = mlfr_pkg::SLP_LEFT;
                n_state = i_sts.full ? mlfr_pkg::ST_PREP : mlfr_pkg::ST_SHIFT;
            end
            mlfr_pkg::ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = mlfr_pkg::ST_DSTART;
            end
            mlfr_pkg::ST_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = mlfr_pkg::ST_DWAIT;
            end
            mlfr_pkg::ST_DWAIT: begin
                if (!i_sts.div_busy) begin
                    o_cmd.save = 1'b1;
                    if (r_slp == mlfr_pkg::SLP_CENT) begin
                        n_slp   = mlfr_pkg::SLP_LEFT;
                        n_state = mlfr_pkg::ST_MINMOD;
                    end else begin
                        n_slp   = r_slp + 2'd1;
                        n_state = mlfr_pkg::ST_PREP;
                    end
                end
            end
            mlfr_pkg::ST_MINMOD: begin
                o_cmd.minmod = 1'b1;
                n_state      = mlfr_pkg::ST_MUL;
            end
            mlfr_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = mlfr_pkg::ST_FACE;
            end
            mlfr_pkg::ST_FACE: begin
                o_cmd.face = 1'b1;
                if (r_qty == mlfr_pkg::QTY_VELO) begin
                    n_qty   = mlfr_pkg::QTY_DENS;
                    n_state = mlfr_pkg::ST_OUT;
                end else begin
                    n_qty   = r_qty + 2'd1;
                    n_state = mlfr_pkg::ST_PREP;
                end
            end
            mlfr_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = mlfr_pkg::ST_SHIFT;
                end
            end
            mlfr_pkg::ST_SHIFT: begin
                o_cmd.shift = 1'b1;
                n_state     = mlfr_pkg::ST_IDLE;
            end
            default: begin
                n_state = mlfr_pkg::ST_IDLE;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/core/mlfr_dp.sv */
// Datapath: cell window, slope operands, shared divider, minmod, face values, output word.
`default_nettype none
module mlfr_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire mlfr_pkg::t_cmd       i_cmd,
    output mlfr_pkg::t_sts            o_sts,
    input  wire logic [159:0]         i_s_tdata,
    input  wire logic [0:0]           i_s_tuser,
    output logic                      o_m_tvalid,
    input  wire logic                 i_m_tready,
    output logic [191:0]              o_m_tdata
);

    localparam int DW = mlfr_pkg::DW;

    function automatic logic signed [DW-1:0] sat_sum(input logic signed [mlfr_pkg::SUM_W-1:0] v);
        logic signed [mlfr_pkg::SUM_W-1:0] hi;
        logic signed [mlfr_pkg::SUM_W-1:0] lo;
        hi = mlfr_pkg::SUM_W'(mlfr_pkg::DW_MAX);
        lo = mlfr_pkg::SUM_W'(mlfr_pkg::DW_MIN);
        if (v > hi) begin
            return mlfr_pkg::DW_MAX;
        end else if (v < lo) begin
            return mlfr_pkg::DW_MIN;
        end
        return v[DW-1:0];
    endfunction

    // window, older entry first
    logic signed [DW-1:0] r_dens_win [2];
    logic signed [DW-1:0] r_pres_win [2];
    logic signed [DW-1:0] r_velo_win [2];
    logic signed [DW-1:0] r_edge_win [3];
    logic [1:0]           r_fill;

    logic signed [DW-1:0] r_cur_dens, r_cur_pres, r_cur_velo, r_cur_le, r_cur_re;

    logic signed [DW-1:0] w_l, w_c, w_r;
    logic signed [mlfr_pkg::DIFF_W-1:0] w_num;
    logic signed [mlfr_pkg::DEN_W-1:0]  w_den;
    logic signed [mlfr_pkg::DIFF_W-1:0] r_num;
    logic signed [mlfr_pkg::DEN_W-1:0]  r_den;
    logic [mlfr_pkg::DIFF_W-1:0]        w_num_mag;
    logic [mlfr_pkg::DEN_W-1:0]         w_den_mag;
    logic [mlfr_pkg::UN_W-1:0]          w_un;

    logic                               w_div_busy;
    logic [mlfr_pkg::DVD_W-1:0]         w_quo;
    logic signed [DW-1:0]               w_slope;
    logic                               w_neg;
    logic signed [DW-1:0]               r_slope [3];

    logic [DW-1:0]                      w_ml, w_mr, w_mc, w_min;
    logic                               w_opp;
    logic [DW-1:0]                      r_m;
    logic                               r_sneg;

    logic signed [mlfr_pkg::DIFF_W-1:0] w_width;
    logic [mlfr_pkg::DIFF_W-1:0]        w_width_mag;
    logic [mlfr_pkg::PROD_W-1:0]        r_prod;
    logic                               r_oneg;

    logic signed [mlfr_pkg::SUM_W-1:0]  w_off;
    logic signed [mlfr_pkg::SUM_W-1:0]  w_cext;
    logic signed [DW-1:0]               r_lo [3];
    logic signed [DW-1:0]               r_hi [3];
    logic                               r_out_valid;
    logic [191:0]                       r_out_data;

    // operand selection for the current quantity
    always_comb begin
        case (i_cmd.qty)
            mlfr_pkg::QTY_DENS: begin
                w_l = r_dens_win[0]; w_c = r_dens_win[1]; w_r = r_cur_dens;
            end
            mlfr_pkg::QTY_PRES: begin
                w_l = r_pres_win[0]; w_c = r_pres_win[1]; w_r = r_cur_pres;
            end
            default: begin
                w_l = r_velo_win[0]; w_c = r_velo_win[1]; w_r = r_cur_velo;
            end
        endcase
    end

    always_comb begin
        case (i_cmd.slp)
            mlfr_pkg::SLP_LEFT: begin
                w_num = mlfr_pkg::DIFF_W'(w_c) - mlfr_pkg::DIFF_W'(w_l);
                w_den = mlfr_pkg::DEN_W'(r_edge_win[2]) - mlfr_pkg::DEN_W'(r_edge_win[0]);
            end
            mlfr_pkg::SLP_RIGHT: begin
                w_num = mlfr_pkg::DIFF_W'(w_r) - mlfr_pkg::DIFF_W'(w_c);
                w_den = mlfr_pkg::DEN_W'(r_cur_re) - mlfr_pkg::DEN_W'(r_edge_win[1]);
            end
            default: begin
                w_num = mlfr_pkg::DIFF_W'(w_r) - mlfr_pkg::DIFF_W'(w_l);
                w_den = (mlfr_pkg::DEN_W'(r_cur_re) + mlfr_pkg::DEN_W'(r_edge_win[2]))
                      - (mlfr_pkg::DEN_W'(r_edge_win[0]) + mlfr_pkg::DEN_W'(r_edge_win[1]));
            end
        endcase
    end

    assign w_num_mag = r_num[mlfr_pkg::DIFF_W-1] ? mlfr_pkg::DIFF_W'(-r_num)
                                                 : mlfr_pkg::DIFF_W'(r_num);
    assign w_den_mag = r_den[mlfr_pkg::DEN_W-1] ? mlfr_pkg::DEN_W'(-r_den)
                                                : mlfr_pkg::DEN_W'(r_den);
    assign w_un      = {w_num_mag, 1'b0};

    mlfr_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend ({w_un, {mlfr_pkg::FB{1'b0}}}),
        .i_divisor  (w_den_mag),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    // saturate the quotient; zero numerator and zero width handled here
    assign w_neg = r_num[mlfr_pkg::DIFF_W-1] ^ r_den[mlfr_pkg::DEN_W-1];
    always_comb begin
        if (r_num == '0) begin
            w_slope = '0;
        end else if (r_den == '0) begin
            w_slope = r_num[mlfr_pkg::DIFF_W-1] ? mlfr_pkg::DW_MIN : mlfr_pkg::DW_MAX;
        end else if (w_quo[mlfr_pkg::DVD_W-1:DW-1] != '0) begin
            w_slope = w_neg ? mlfr_pkg::DW_MIN : mlfr_pkg::DW_MAX;
        end else begin
            w_slope = w_neg ? -$signed(w_quo[DW-1:0]) : $signed(w_quo[DW-1:0]);
        end
    end

    // minmod
    assign w_ml  = r_slope[0][DW-1] ? DW'(-r_slope[0]) : DW'(r_slope[0]);
    assign w_mr  = r_slope[1][DW-1] ? DW'(-r_slope[1]) : DW'(r_slope[1]);
    assign w_mc  = r_slope[2][DW-1] ? DW'(-r_slope[2]) : DW'(r_slope[2]);
    assign w_opp = (r_slope[0] > 0 && r_slope[1] < 0) || (r_slope[0] < 0 && r_slope[1] > 0);
    always_comb begin
        w_min = w_ml;
        if (w_mr < w_min) begin
            w_min = w_mr;
        end
        if (w_mc < w_min) begin
            w_min = w_mc;
        end
    end

    assign w_width     = mlfr_pkg::DIFF_W'(r_edge_win[2]) - mlfr_pkg::DIFF_W'(r_edge_win[1]);
    assign w_width_mag = w_width[mlfr_pkg::DIFF_W-1] ? mlfr_pkg::DIFF_W'(-w_width)
                                                     : mlfr_pkg::DIFF_W'(w_width);

    // offset = |slope| * |width| / 2^(FB+1)
    assign w_off  = r_oneg ? -$signed({2'b00, r_prod[mlfr_pkg::PROD_W-1:mlfr_pkg::FB+1]})
                           :  $signed({2'b00, r_prod[mlfr_pkg::PROD_W-1:mlfr_pkg::FB+1]});
    assign w_cext = mlfr_pkg::SUM_W'(w_c);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            for (int i = 0; i < 2; i++) begin
                r_dens_win[i] <= '0;
                r_pres_win[i] <= '0;
                r_velo_win[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_edge_win[i] <= '0;
            end
        end else if (i_cmd.load && i_s_tuser[0]) begin
            r_fill <= '0;
            for (int i = 0; i < 2; i++) begin
                r_dens_win[i] <= '0;
                r_pres_win[i] <= '0;
                r_velo_win[i] <= '0;
            end
            for (int i = 0; i < 3; i++) begin
                r_edge_win[i] <= '0;
            end
        end else if (i_cmd.shift) begin
            r_dens_win[0] <= r_dens_win[1];
            r_dens_win[1] <= r_cur_dens;
            r_pres_win[0] <= r_pres_win[1];
            r_pres_win[1] <= r_cur_pres;
            r_velo_win[0] <= r_velo_win[1];
            r_velo_win[1] <= r_cur_velo;
            r_edge_win[0] <= r_edge_win[1];
            r_edge_win[1] <= r_cur_le;
            r_edge_win[2] <= r_cur_re;
            if (r_fill != 2'd2) begin
                r_fill <= r_fill + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cur_dens <= i_s_tdata[31:0];
            r_cur_pres <= i_s_tdata[63:32];
            r_cur_velo <= i_s_tdata[95:64];
            r_cur_le   <= i_s_tdata[127:96];
            r_cur_re   <= i_s_tdata[159:128];
        end
        if (i_cmd.prep) begin
            r_num <= w_num;
            r_den <= w_den;
        end
        if (i_cmd.save) begin
            r_slope[i_cmd.slp] <= w_slope;
        end
        if (i_cmd.minmod) begin
            r_m    <= w_opp ? '0 : w_min;
            r_sneg <= !(r_slope[0] > 0);
        end
        if (i_cmd.mul) begin
            r_prod <= mlfr_pkg::PROD_W'(r_m) * mlfr_pkg::PROD_W'(w_width_mag);
            r_oneg <= r_sneg ^ w_width[mlfr_pkg::DIFF_W-1];
        end
        if (i_cmd.face) begin
            r_lo[i_cmd.qty] <= sat_sum(w_cext - w_off);
            r_hi[i_cmd.qty] <= sat_sum(w_cext + w_off);
        end
        if (i_cmd.out_load) begin
            r_out_data <= {r_hi[2], r_hi[1], r_hi[0], r_lo[2], r_lo[1], r_lo[0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_sts.full     = (r_fill == 2'd2);
    assign o_sts.div_busy = w_div_busy;
    assign o_sts.out_free = !r_out_valid || i_m_tready;
    assign o_m_tvalid     = r_out_valid;
    assign o_m_tdata      = r_out_data;

endmodule
`default_nettype wire

/* rtl/core/minmod_limited_face_reconstruction.sv */
// Top level: minmod-limited face reconstruction over a stream of 1D cells.
//
// Slave stream takes one cell per word: tdata carries density, pressure,
// velocity, left edge and right edge (32-bit signed Q16.16 each); tuser[0]
// marks the first cell of a new grid and empties the three-cell window.
// Master stream gives, for each cell after the second of a run, the left and
// right face values of the previous cell.
// Each slope is one run of the shared radix-2 divider, with its operands
// latched before the run and its quotient saved after it; nine slopes per
// cell set the pace. A cell that only fills the window is loaded, checked
// and shifted in with no division. No new cell is taken until the block is
// through with the last one.
// The result sits in an output register; while the receiver stalls the
// block still takes the next cell and computes it, and waits only when a
// second result is ready before the first is taken.
// Reset (synchronous, active low) empties the window and drops any word.
`default_nettype none
module minmod_limited_face_reconstruction (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [159:0] i_s_tdata,  // density, pressure, velocity, left_edge, right_edge
    input  wire logic [0:0]   i_s_tuser,  // start_of_run
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [191:0]      o_m_tdata   // left_face_density, left_face_pressure,
                                          // left_face_velocity, right_face_density,
                                          // right_face_pressure, right_face_velocity
);

    mlfr_pkg::t_cmd w_cmd;
    mlfr_pkg::t_sts w_sts;

    mlfr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    mlfr_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready && i_s_tuser[0]) |=> !w_sts.full)
        else $error("start of run did not empty the window");

    a_ready_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> !w_sts.div_busy)
        else $error("input ready while divider busy");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_tvalid || i_m_tready))
        else $error("result word overwritten before taken");

endmodule
`default_nettype wire
